/* rtl/rcsa_pkg.sv */
// ----------------------------------------------------------------------------
// rcsa_pkg: shared types and constants of the reliable channel header engine
// Status codes, command codes and the word and result structures.
// ----------------------------------------------------------------------------
package rcsa_pkg;

  localparam int SEQ_W   = 30;
  localparam int WORD_W  = 32;
  localparam int CNT_W   = 8;
  localparam int UNACK_W = 16;
  localparam int STAT_W  = 3;

  localparam logic CMD_TX = 1'b0;
  localparam logic CMD_RX = 1'b1;

  localparam logic [STAT_W-1:0] ST_SENT     = 3'd0;
  localparam logic [STAT_W-1:0] ST_ACCEPTED = 3'd1;
  localparam logic [STAT_W-1:0] ST_ORDER    = 3'd2;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd3;
  localparam logic [STAT_W-1:0] ST_SECURITY = 3'd4;

  localparam logic [UNACK_W-1:0] UNACK_MAX = '1;

  typedef struct packed {
    logic              cmd;
    logic              frag_pending;
    logic              reliable_pending;
    logic [CNT_W-1:0]  reliable_count;
    logic [WORD_W-1:0] rx_seq_word;
    logic [WORD_W-1:0] rx_ack_word;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [WORD_W-1:0]  tx_seq_word;
    logic [WORD_W-1:0]  tx_ack_word;
    logic               send_fragment;
    logic               send_reliable;
    logic [SEQ_W-1:0]   gap;
    logic               is_fragment;
    logic [UNACK_W-1:0] release_reliable;
    logic               release_fragment;
  } result_t;

endpackage

/* rtl/rcsa_engine.sv */
// ----------------------------------------------------------------------------
// rcsa_engine: channel state and header logic
// Holds the sequence, ack and reliable-bit state and works out the result
// of one header word in a single pass; state moves on when en is high.
// ----------------------------------------------------------------------------
module rcsa_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  rcsa_pkg::item_t  item,
  output rcsa_pkg::result_t res
);

  logic [rcsa_pkg::SEQ_W-1:0]   out_seq, out_seq_next;
  logic [rcsa_pkg::SEQ_W-1:0]   in_seq, in_seq_next;
  logic [rcsa_pkg::SEQ_W-1:0]   in_ack, in_ack_next;
  logic [rcsa_pkg::SEQ_W-1:0]   last_reliable_seq, last_reliable_seq_next;
  logic                         out_reliable_bit, out_reliable_bit_next;
  logic                         in_reliable_bit, in_reliable_bit_next;
  logic [rcsa_pkg::UNACK_W-1:0] unacked_reliable, unacked_reliable_next;

  logic [rcsa_pkg::SEQ_W-1:0]   seq_inc;
  logic [rcsa_pkg::SEQ_W-1:0]   rx_seq;
  logic [rcsa_pkg::SEQ_W-1:0]   rx_ack;
  logic [rcsa_pkg::UNACK_W:0]   unacked_sum;
  logic                         hf, hr, rel;

  assign seq_inc     = out_seq + 1'b1;
  assign rx_seq      = item.rx_seq_word[rcsa_pkg::SEQ_W-1:0];
  assign rx_ack      = item.rx_ack_word[rcsa_pkg::SEQ_W-1:0];
  assign unacked_sum = {1'b0, unacked_reliable}
                     + {{(rcsa_pkg::UNACK_W+1-rcsa_pkg::CNT_W){1'b0}}, item.reliable_count};
  // previous reliable packet must be acknowledged before new reliable data
  assign hf  = (in_ack >= last_reliable_seq) & item.frag_pending;
  assign hr  = (in_ack >= last_reliable_seq) & item.reliable_pending;
  assign rel = hf | hr;

  always_comb begin
    out_seq_next           = out_seq;
    in_seq_next            = in_seq;
    in_ack_next            = in_ack;
    last_reliable_seq_next = last_reliable_seq;
    out_reliable_bit_next  = out_reliable_bit;
    in_reliable_bit_next   = in_reliable_bit;
    unacked_reliable_next  = unacked_reliable;
    res                    = '0;
    if (item.cmd == rcsa_pkg::CMD_TX) begin
      out_seq_next      = seq_inc;
      if (rel) last_reliable_seq_next = seq_inc;
      if (hr) begin
        unacked_reliable_next = unacked_sum[rcsa_pkg::UNACK_W] ? rcsa_pkg::UNACK_MAX
                              : unacked_sum[rcsa_pkg::UNACK_W-1:0];
      end
      res.status        = rcsa_pkg::ST_SENT;
      res.tx_seq_word   = {rel, hf, seq_inc};
      res.tx_ack_word   = {out_reliable_bit, 1'b0, in_seq};
      res.send_fragment = hf;
      res.send_reliable = hr;
    end else if (item.rx_ack_word[rcsa_pkg::SEQ_W]) begin
      res.status = rcsa_pkg::ST_SECURITY;
    end else if (rx_seq < in_seq) begin
      res.status = rcsa_pkg::ST_ORDER;
    end else if (rx_seq == in_seq) begin
      res.status = rcsa_pkg::ST_DUP;
    end else begin
      res.status      = rcsa_pkg::ST_ACCEPTED;
      res.gap         = rx_seq - in_seq;
      res.is_fragment = item.rx_seq_word[rcsa_pkg::SEQ_W];
      in_seq_next     = rx_seq;
      in_ack_next     = rx_ack;
      if (item.rx_seq_word[rcsa_pkg::WORD_W-1]) out_reliable_bit_next = ~out_reliable_bit;
      if (rx_ack >= last_reliable_seq) begin
        // ack bit toggled: the peer has the last reliable packet
        if (item.rx_ack_word[rcsa_pkg::WORD_W-1] != in_reliable_bit) begin
          in_reliable_bit_next = item.rx_ack_word[rcsa_pkg::WORD_W-1];
          res.release_fragment = item.frag_pending;
          res.release_reliable = unacked_reliable;
        end
        unacked_reliable_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_seq           <= '0;
      in_seq            <= '0;
      in_ack            <= '0;
      last_reliable_seq <= '0;
      out_reliable_bit  <= 1'b0;
      in_reliable_bit   <= 1'b0;
      unacked_reliable  <= '0;
    end else if (en) begin
      out_seq           <= out_seq_next;
      in_seq            <= in_seq_next;
      in_ack            <= in_ack_next;
      last_reliable_seq <= last_reliable_seq_next;
      out_reliable_bit  <= out_reliable_bit_next;
      in_reliable_bit   <= in_reliable_bit_next;
      unacked_reliable  <= unacked_reliable_next;
    end
  end

  a_tx_advances: assert property (@(posedge clk) disable iff (rst)
    (en && item.cmd == rcsa_pkg::CMD_TX) |=> out_seq == $past(out_seq) + 1'b1)
    else $error("outgoing sequence did not advance on transmit");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(out_seq) && $stable(in_seq) && $stable(unacked_reliable)))
    else $error("state moved without a word");

  a_drop_holds: assert property (@(posedge clk) disable iff (rst)
    (en && item.cmd == rcsa_pkg::CMD_RX && res.status != rcsa_pkg::ST_ACCEPTED)
    |=> ($stable(in_seq) && $stable(in_ack) && $stable(unacked_reliable)))
    else $error("dropped packet changed receive state");

  a_tx_no_release: assert property (@(posedge clk) disable iff (rst)
    (item.cmd == rcsa_pkg::CMD_TX) |-> (res.release_reliable == '0 && res.gap == '0))
    else $error("transmit result carries receive fields");

endmodule

/* rtl/reliable_channel_seq_ack_top.sv */
// ----------------------------------------------------------------------------
// reliable_channel_seq_ack_top: reliable datagram channel header engine
// Input word register, single-pass header logic and output word register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one header word: cmd selects
//   transmit (build sequence and ack words) or receive (check and accept a
//   received header). Every word gives exactly one result on the output
//   channel (out_valid/out_stall).
//   The word passes from the accepting edge into the input register, then
//   through the header logic into the output register when that is free
//   or being read, and out_valid rises with it.
//   Throughput is one word per cycle while out_stall stays low; the channel
//   state is updated as a word moves from the input register to the output
//   register, so the next word sees it at once.
//   Reset clears all sequence, ack and reliable-bit state and both valid
//   flags. While the receiver stalls, the result holds in the output
//   register, one more word waits in the input register, and in_stall
//   rises only when both are full.
// ----------------------------------------------------------------------------
module reliable_channel_seq_ack_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic        frag_pending,
  input  logic        reliable_pending,
  input  logic [7:0]  reliable_count,
  input  logic [31:0] rx_seq_word,
  input  logic [31:0] rx_ack_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] tx_seq_word,
  output logic [31:0] tx_ack_word,
  output logic        send_fragment,
  output logic        send_reliable,
  output logic [29:0] gap,
  output logic        is_fragment,
  output logic [15:0] release_reliable,
  output logic        release_fragment
);

  logic              held_valid;
  rcsa_pkg::item_t   held;
  rcsa_pkg::result_t res_next;
  rcsa_pkg::result_t res;
  logic              advance;
  logic              in_take;

  // the held word moves on when the output register is free or being read
  assign advance  = held_valid & (~out_valid | ~out_stall);
  assign in_stall = held_valid & ~advance;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      held.cmd              <= cmd;
      held.frag_pending     <= frag_pending;
      held.reliable_pending <= reliable_pending;
      held.reliable_count   <= reliable_count;
      held.rx_seq_word      <= rx_seq_word;
      held.rx_ack_word      <= rx_ack_word;
    end
  end

  rcsa_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .item (held),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res <= res_next;
  end

  assign status           = res.status;
  assign tx_seq_word      = res.tx_seq_word;
  assign tx_ack_word      = res.tx_ack_word;
  assign send_fragment    = res.send_fragment;
  assign send_reliable    = res.send_reliable;
  assign gap              = res.gap;
  assign is_fragment      = res.is_fragment;
  assign release_reliable = res.release_reliable;
  assign release_fragment = res.release_fragment;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !advance)
    else $error("stalled result overwritten");

  a_held_moves: assert property (@(posedge clk) disable iff (rst)
    (held_valid && !out_valid) |=> out_valid)
    else $error("held word not passed on to free output register");

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    in_take |=> held_valid)
    else $error("accepted word lost");

endmodule

/* test/tb_reliable_channel_seq_ack_top.sv */
// ----------------------------------------------------------------------------
// tb_reliable_channel_seq_ack_top: self-checking bench for the header engine
// A driver sends transmit and receive header words from a queue filled up
// front. A predictor keeps its own sequence and ack state and works out each
// result. A monitor compares every result with the oldest prediction, while
// both sides of the block idle and stall in random bursts, but for the calm last words.
// ----------------------------------------------------------------------------
module tb_reliable_channel_seq_ack_top;

  localparam int TOTAL_WORDS = 1050;
  localparam int CALM_WORDS  = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int QUEUE_DEPTH = 2048;
  localparam int SEQ_REL_BIT  = 31;
  localparam int SEQ_FRAG_BIT = 30;
  localparam int ACK_REL_BIT  = 31;
  localparam int ACK_SEC_BIT  = 30;

  typedef struct {
    rcsa_pkg::item_t w;
    bit              hold;
    bit              calm;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  rcsa_pkg::item_t cur_word = '0;

  logic                         in_stall;
  logic                         cmd;
  logic                         frag_pending;
  logic                         reliable_pending;
  logic [rcsa_pkg::CNT_W-1:0]   reliable_count;
  logic [rcsa_pkg::WORD_W-1:0]  rx_seq_word;
  logic [rcsa_pkg::WORD_W-1:0]  rx_ack_word;
  logic                         out_valid;
  logic [rcsa_pkg::STAT_W-1:0]  status;
  logic [rcsa_pkg::WORD_W-1:0]  tx_seq_word;
  logic [rcsa_pkg::WORD_W-1:0]  tx_ack_word;
  logic                         send_fragment;
  logic                         send_reliable;
  logic [rcsa_pkg::SEQ_W-1:0]   gap;
  logic                         is_fragment;
  logic [rcsa_pkg::UNACK_W-1:0] release_reliable;
  logic                         release_fragment;

  assign cmd              = cur_word.cmd;
  assign frag_pending     = cur_word.frag_pending;
  assign reliable_pending = cur_word.reliable_pending;
  assign reliable_count   = cur_word.reliable_count;
  assign rx_seq_word      = cur_word.rx_seq_word;
  assign rx_ack_word      = cur_word.rx_ack_word;

  reliable_channel_seq_ack_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .frag_pending(frag_pending), .reliable_pending(reliable_pending),
    .reliable_count(reliable_count), .rx_seq_word(rx_seq_word),
    .rx_ack_word(rx_ack_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .tx_seq_word(tx_seq_word), .tx_ack_word(tx_ack_word),
    .send_fragment(send_fragment), .send_reliable(send_reliable), .gap(gap),
    .is_fragment(is_fragment), .release_reliable(release_reliable),
    .release_fragment(release_fragment)
  );

  always #4 clk = ~clk;

  // pending words and awaited results, each read from a head index
  stim_t             outgoing_words[QUEUE_DEPTH];
  rcsa_pkg::result_t awaited_results[QUEUE_DEPTH];
  int                send_head = 0;
  int                due_head = 0;
  int                due_tail = 0;
  int                words_queued = 0;
  int                words_accepted = 0;
  int                mismatches = 0;
  int                cycle_count = 0;
  int                send_gap = 0;
  int                stall_left = 0;
  bit                calm_now = 1'b0;
  stim_t             next_stim;
  rcsa_pkg::result_t due;

  // channel state as the predictor sees it
  logic [rcsa_pkg::SEQ_W-1:0]   tx_seq_q = '0;
  logic [rcsa_pkg::SEQ_W-1:0]   rx_seq_q = '0;
  logic [rcsa_pkg::SEQ_W-1:0]   peer_ack_q = '0;
  logic [rcsa_pkg::SEQ_W-1:0]   rel_seq_q = '0;
  logic                         tx_rel_bit_q = 1'b0;
  logic                         rx_rel_bit_q = 1'b0;
  logic [rcsa_pkg::UNACK_W-1:0] unacked_q = '0;

  // stimulus side tracking, only used to shape well-formed traffic
  logic [rcsa_pkg::SEQ_W-1:0] gen_tx = '0;
  logic [rcsa_pkg::SEQ_W-1:0] gen_rx_seq = '0;
  bit                         hold_next = 1'b0;
  bit                         calm_mode = 1'b0;

  function automatic rcsa_pkg::result_t predict_header(input rcsa_pkg::item_t w);
    rcsa_pkg::result_t          r;
    logic                       hf;
    logic                       hr;
    logic                       rel;
    logic [rcsa_pkg::SEQ_W-1:0] seq;
    logic [rcsa_pkg::UNACK_W:0] total;
    r = '0;
    if (w.cmd == rcsa_pkg::CMD_TX) begin
      tx_seq_q = tx_seq_q + 1'b1;
      hf = 1'b0;
      hr = 1'b0;
      // plain compare, no wrap handling
      if (peer_ack_q >= rel_seq_q) begin
        hf = w.frag_pending;
        hr = w.reliable_pending;
      end
      rel = hf | hr;
      if (rel) rel_seq_q = tx_seq_q;
      if (hr) begin
        total = {1'b0, unacked_q}
              + {{(rcsa_pkg::UNACK_W+1-rcsa_pkg::CNT_W){1'b0}}, w.reliable_count};
        unacked_q = (total > {1'b0, rcsa_pkg::UNACK_MAX}) ? rcsa_pkg::UNACK_MAX
                  : total[rcsa_pkg::UNACK_W-1:0];
      end
      r.status        = rcsa_pkg::ST_SENT;
      r.tx_seq_word   = {rel, hf, tx_seq_q};
      r.tx_ack_word   = {tx_rel_bit_q, 1'b0, rx_seq_q};
      r.send_fragment = hf;
      r.send_reliable = hr;
    end else begin
      seq = w.rx_seq_word[rcsa_pkg::SEQ_W-1:0];
      if (w.rx_ack_word[ACK_SEC_BIT]) begin
        r.status = rcsa_pkg::ST_SECURITY;
      end else if (seq < rx_seq_q) begin
        r.status = rcsa_pkg::ST_ORDER;
      end else if (seq == rx_seq_q) begin
        r.status = rcsa_pkg::ST_DUP;
      end else begin
        r.status      = rcsa_pkg::ST_ACCEPTED;
        r.gap         = seq - rx_seq_q;
        r.is_fragment = w.rx_seq_word[SEQ_FRAG_BIT];
        rx_seq_q      = seq;
        peer_ack_q    = w.rx_ack_word[rcsa_pkg::SEQ_W-1:0];
        if (w.rx_seq_word[SEQ_REL_BIT]) tx_rel_bit_q = ~tx_rel_bit_q;
        if (peer_ack_q >= rel_seq_q) begin
          // release only on an ack toggle, the counter clears either way
          if (w.rx_ack_word[ACK_REL_BIT] != rx_rel_bit_q) begin
            rx_rel_bit_q       = w.rx_ack_word[ACK_REL_BIT];
            r.release_fragment = w.frag_pending;
            r.release_reliable = unacked_q;
          end
          unacked_q = '0;
        end
      end
    end
    return r;
  endfunction

  function automatic rcsa_pkg::item_t tx_word(input logic fp, input logic rp,
                                              input logic [rcsa_pkg::CNT_W-1:0] cnt);
    rcsa_pkg::item_t w;
    w.cmd              = rcsa_pkg::CMD_TX;
    w.frag_pending     = fp;
    w.reliable_pending = rp;
    w.reliable_count   = cnt;
    w.rx_seq_word      = $urandom;
    w.rx_ack_word      = $urandom;
    return w;
  endfunction

  function automatic rcsa_pkg::item_t rx_word(input logic [1:0] seq_flags,
                                              input logic [rcsa_pkg::SEQ_W-1:0] seq,
                                              input logic [1:0] ack_flags,
                                              input logic [rcsa_pkg::SEQ_W-1:0] ack,
                                              input logic fp);
    rcsa_pkg::item_t w;
    w.cmd              = rcsa_pkg::CMD_RX;
    w.frag_pending     = fp;
    w.reliable_pending = 1'($urandom_range(0, 1));
    w.reliable_count   = 8'($urandom_range(0, 255));
    w.rx_seq_word      = {seq_flags, seq};
    w.rx_ack_word      = {ack_flags, ack};
    return w;
  endfunction

  task automatic queue_word(input rcsa_pkg::item_t w);
    stim_t s;
    s.w    = w;
    s.hold = hold_next;
    s.calm = calm_mode;
    hold_next = 1'b0;
    outgoing_words[words_queued] = s;
    words_queued++;
    if (w.cmd == rcsa_pkg::CMD_TX) begin
      gen_tx = gen_tx + 1'b1;
    end else if (!w.rx_ack_word[ACK_SEC_BIT] &&
                 w.rx_seq_word[rcsa_pkg::SEQ_W-1:0] > gen_rx_seq) begin
      gen_rx_seq = w.rx_seq_word[rcsa_pkg::SEQ_W-1:0];
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        words_accepted++;
        awaited_results[due_tail] = predict_header(cur_word);
        due_tail++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (send_head < words_queued &&
                     !(outgoing_words[send_head].hold && due_tail != due_head)) begin
          if (!outgoing_words[send_head].calm && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 18);
            in_valid <= 1'b0;
          end else begin
            next_stim = outgoing_words[send_head];
            send_head++;
            cur_word <= next_stim.w;
            calm_now <= next_stim.calm;
            in_valid <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm_now && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_head == due_tail) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result word with nothing awaited, status %0d", status);
      end else begin
        due = awaited_results[due_head];
        due_head++;
        compare_field("status", 32'(due.status), 32'(status));
        compare_field("tx_seq_word", due.tx_seq_word, tx_seq_word);
        compare_field("tx_ack_word", due.tx_ack_word, tx_ack_word);
        compare_field("send_fragment", 32'(due.send_fragment), 32'(send_fragment));
        compare_field("send_reliable", 32'(due.send_reliable), 32'(send_reliable));
        compare_field("gap", 32'(due.gap), 32'(gap));
        compare_field("is_fragment", 32'(due.is_fragment), 32'(is_fragment));
        compare_field("release_reliable", 32'(due.release_reliable),
                      32'(release_reliable));
        compare_field("release_fragment", 32'(due.release_fragment),
                      32'(release_fragment));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** reliable_channel_seq_ack_top: FAILED **");
      $finish;
    end
  end

  initial begin
    int   kind;
    int   n;
    int   back;
    bit   sat_done;
    logic sat_bit;
    sat_done = 1'b0;

    // directed: window open and closed, every drop kind, toggles and counts
    queue_word(tx_word(1'b0, 1'b0, 8'd0));
    queue_word(tx_word(1'b1, 1'b1, 8'd255));
    queue_word(tx_word(1'b1, 1'b1, 8'd17));
    queue_word(rx_word(2'b11, '1, 2'b11, '1, 1'b1));
    queue_word(rx_word(2'b00, 30'd0, 2'b00, 30'd0, 1'b0));
    queue_word(rx_word(2'b11, 30'd5, 2'b00, 30'd1, 1'b1));
    queue_word(rx_word(2'b00, 30'd3, 2'b00, 30'd0, 1'b0));
    queue_word(rx_word(2'b01, 30'd5, 2'b10, 30'd2, 1'b1));
    queue_word(rx_word(2'b00, 30'd6, 2'b10, 30'd3, 1'b1));
    queue_word(tx_word(1'b0, 1'b1, 8'd0));
    queue_word(tx_word(1'b1, 1'b1, 8'd90));
    queue_word(rx_word(2'b00, 30'd7, 2'b10, 30'd4, 1'b0));
    queue_word(tx_word(1'b0, 1'b1, 8'd200));
    queue_word(rx_word(2'b10, 30'd8, 2'b00, 30'd6, 1'b0));
    queue_word(tx_word(1'b1, 1'b0, 8'd255));
    queue_word(rx_word(2'b01, 30'd1008, 2'b00, 30'd2, 1'b1));
    queue_word(rx_word(2'b00, 30'd0, 2'b01, '1, 1'b0));

    // sender waits for the directed words to drain before the random part
    hold_next = 1'b1;
    while (words_queued < TOTAL_WORDS) begin
      calm_mode = (words_queued > TOTAL_WORDS - CALM_WORDS);
      if (!sat_done && words_queued > 400) begin
        // ack far ahead keeps the window open so the sent counter saturates
        sat_done  = 1'b1;
        hold_next = 1'b1;
        sat_bit   = 1'($urandom_range(0, 1));
        queue_word(rx_word(2'b00, gen_rx_seq + 30'd1, {sat_bit, 1'b0},
                           gen_tx + 30'd400, 1'b0));
        repeat (280) queue_word(tx_word(1'($urandom_range(0, 1)), 1'b1,
                                        8'($urandom_range(240, 255))));
        queue_word(rx_word(2'b00, gen_rx_seq + 30'd1, {~sat_bit, 1'b0},
                           gen_tx + 30'd400, 1'b1));
      end else begin
        kind = $urandom_range(0, 9);
        n    = $urandom_range(4, 24);
        repeat (n) begin
          if (kind < 7) begin
            if ($urandom_range(0, 1) == 0) begin
              queue_word(tx_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 8'(($urandom_range(0, 7) == 0) ? 255
                                    : $urandom_range(0, 255))));
            end else begin
              back = $urandom_range(0, 2);
              queue_word(rx_word(2'($urandom_range(0, 3)),
                                 30'(gen_rx_seq + (($urandom_range(0, 15) == 0) ?
                                   $urandom_range(4, 5000) : $urandom_range(1, 3))),
                                 {1'($urandom_range(0, 1)), 1'b0},
                                 (gen_tx > 30'(back)) ? gen_tx - 30'(back) : 30'd0,
                                 1'($urandom_range(0, 1))));
            end
          end else begin
            case ($urandom_range(0, 3))
              0: queue_word(rx_word(2'($urandom), 30'($urandom), {1'($urandom), 1'b1},
                                    30'($urandom), 1'($urandom_range(0, 1))));
              1: queue_word(rx_word(2'($urandom),
                                    30'($urandom_range(0, 32'(gen_rx_seq) - 1)),
                                    {1'($urandom), 1'b0}, 30'($urandom),
                                    1'($urandom_range(0, 1))));
              2: queue_word(rx_word(2'($urandom), gen_rx_seq, {1'($urandom), 1'b0},
                                    30'($urandom), 1'($urandom_range(0, 1))));
              default: queue_word(rx_word(2'($urandom),
                                          30'(gen_rx_seq + $urandom_range(1, 3)),
                                          {1'($urandom), 1'b0}, 30'($urandom),
                                          1'($urandom_range(0, 1))));
            endcase
          end
        end
      end
    end

    // top of the sequence space, after which nothing more can be accepted
    calm_mode = 1'b1;
    queue_word(rx_word(2'b11, '1, 2'b10, '1, 1'b1));
    queue_word(tx_word(1'b1, 1'b1, 8'd255));
    queue_word(rx_word(2'b00, 30'd0, 2'b00, 30'd0, 1'b1));
    queue_word(rx_word(2'b11, '1, 2'b00, '1, 1'b0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (words_accepted < words_queued || due_head != due_tail) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && due_head == due_tail) begin
      $display("** reliable_channel_seq_ack_top: PASSED **");
    end else begin
      $display("** reliable_channel_seq_ack_top: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/rcsa_pkg.sv
rtl/rcsa_engine.sv
rtl/reliable_channel_seq_ack_top.sv
test/tb_reliable_channel_seq_ack_top.sv
